FILE: rtl/maf_pkg.sv
package maf_pkg;

	localparam int CHANNELS    = 16;
	localparam int MAX_WINDOW  = 1024;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int POS_W       = $clog2(MAX_WINDOW);
	localparam int FILL_W      = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W    = 32;
	localparam int SUM_W       = 42;
	localparam int ADDR_W      = CH_W + POS_W;
	localparam int STORE_DEPTH = CHANNELS * MAX_WINDOW;
	localparam int CFG_IDX_W   = 2;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STEPS   = SAMPLE_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [SAMPLE_W-1:0]  NORM_OFFSET     = 32'h7FFF_FFFF;
	localparam logic [FILL_W-1:0]    WINDOW_RESET    = FILL_W'(MAX_WINDOW);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE   = 2'd1;

	typedef struct packed {
		logic                in_range;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic load;
		logic in_div;
		logic div_done;
	} back_stat_t;

endpackage

FILE: rtl/maf_front.sv
module maf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [3:0]                     channel_index,
	input  logic [maf_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                           q_valid,
	output maf_pkg::item_t                 q_item,
	input  logic                           q_pop
);

	maf_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	maf_pkg::item_t incoming;

	assign item_ready = (count_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign q_valid    = (count_q != 2'd0);
	assign q_item     = slot_q[rd_ptr_q];

	// classify: an index past the channel count yields a zero result
	always_comb begin
		incoming.in_range = ({1'b0, channel_index} < 5'(maf_pkg::CHANNELS));
		incoming.ch       = maf_pkg::CH_W'(channel_index);
		incoming.sample   = sample_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: rtl/maf_div.sv
module maf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [maf_pkg::SUM_W-1:0]     num,
	input  logic [maf_pkg::FILL_W-1:0]    den,
	output logic                          done,
	output logic [maf_pkg::SAMPLE_W-1:0]  quot
);

	logic                          busy_q;
	logic [maf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [maf_pkg::FILL_W-1:0]    rem_q;
	logic [maf_pkg::SAMPLE_W-1:0]  quo_q;
	logic [maf_pkg::FILL_W-1:0]    den_q;
	logic [maf_pkg::FILL_W-1:0]    rem_n;
	logic [maf_pkg::SAMPLE_W-1:0]  quo_n;

	assign done = busy_q && (cnt_q == maf_pkg::DIV_CNT_W'(maf_pkg::DIV_STEPS - 1));
	assign quot = quo_q;

	// quotient is known to fit 32 bits, so the top dividend bits seed the remainder
	always_comb begin
		logic [maf_pkg::FILL_W:0] t;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < maf_pkg::DIV_BITS; i++) begin
			t = {rem_n, quo_n[maf_pkg::SAMPLE_W-1]};
			quo_n = {quo_n[maf_pkg::SAMPLE_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				rem_n    = maf_pkg::FILL_W'(t - {1'b0, den_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = maf_pkg::FILL_W'(t);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= maf_pkg::FILL_W'(num[maf_pkg::SUM_W-1:maf_pkg::SAMPLE_W]);
			quo_q <= num[maf_pkg::SAMPLE_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) busy_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/maf_back.sv
module maf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  maf_pkg::item_t                q_item,
	output logic                          q_pop,
	input  logic [maf_pkg::FILL_W-1:0]    cap,
	input  logic                          norm_mode,
	input  logic                          clear,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [maf_pkg::SAMPLE_W-1:0]  filtered_value,
	output maf_pkg::back_stat_t           stat
);

	maf_pkg::back_state_t state_q, state_n;

	logic [maf_pkg::SUM_W-1:0]    sum_q    [maf_pkg::CHANNELS];
	logic [maf_pkg::POS_W-1:0]    oldest_q [maf_pkg::CHANNELS];
	logic [maf_pkg::POS_W-1:0]    next_q   [maf_pkg::CHANNELS];
	logic [maf_pkg::FILL_W-1:0]   fill_q   [maf_pkg::CHANNELS];
	logic [maf_pkg::SAMPLE_W-1:0] store_q  [maf_pkg::STORE_DEPTH];
	logic [maf_pkg::SAMPLE_W-1:0] rdata_q;

	logic [maf_pkg::CH_W-1:0]     ch_w_q;
	logic [maf_pkg::SAMPLE_W-1:0] sample_w_q;
	logic [maf_pkg::SUM_W-1:0]    sum_w_q;
	logic [maf_pkg::FILL_W-1:0]   fill_w_q;
	logic [maf_pkg::POS_W-1:0]    wp_w_q;

	logic                          valid_q;
	logic [maf_pkg::SAMPLE_W-1:0]  result_q;

	logic                          out_free;
	logic                          take;
	logic                          load;
	logic                          finish;
	logic                          div_start;
	logic                          div_done;
	logic [maf_pkg::SAMPLE_W-1:0]  mean;
	logic [maf_pkg::SAMPLE_W-1:0]  result_n;
	logic                          evict;
	logic [maf_pkg::POS_W-1:0]     rp;

	function automatic logic [maf_pkg::POS_W-1:0] step_pos(
		input logic [maf_pkg::POS_W-1:0] pos,
		input logic [maf_pkg::FILL_W-1:0] lim
	);
		logic [maf_pkg::FILL_W-1:0] nxt;
		nxt = maf_pkg::FILL_W'(pos) + 1'b1;
		return (nxt >= lim) ? '0 : maf_pkg::POS_W'(nxt);
	endfunction

	assign out_free       = !valid_q || result_ready;
	assign result_valid   = valid_q;
	assign filtered_value = result_q;
	assign rp             = oldest_q[ch_w_q];
	assign evict          = (fill_w_q >= cap);

	maf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_w_q),
		.den    (fill_w_q),
		.done   (div_done),
		.quot   (mean)
	);

	always_comb begin
		state_n   = state_q;
		q_pop     = 1'b0;
		take      = 1'b0;
		load      = 1'b0;
		finish    = 1'b0;
		div_start = 1'b0;
		result_n  = '0;
		case (state_q)
			maf_pkg::B_IDLE: begin
				if (q_valid) begin
					if (q_item.in_range) begin
						q_pop   = 1'b1;
						take    = 1'b1;
						state_n = maf_pkg::B_READ;
					end else if (out_free) begin
						q_pop = 1'b1;
						load  = 1'b1;
					end
				end
			end
			maf_pkg::B_READ: begin
				div_start = 1'b1;
				state_n   = maf_pkg::B_DIV;
			end
			maf_pkg::B_DIV: begin
				if (div_done) state_n = maf_pkg::B_DONE;
			end
			maf_pkg::B_DONE: begin
				if (out_free) begin
					load    = 1'b1;
					finish  = 1'b1;
					state_n = maf_pkg::B_IDLE;
				end
				result_n = norm_mode ? (maf_pkg::NORM_OFFSET + sample_w_q - mean) : mean;
			end
			default: state_n = maf_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		stat.load     = load;
		stat.in_div   = (state_q == maf_pkg::B_DIV);
		stat.div_done = div_done;
	end

	// sample store: write on take, read the oldest entry in the cycle after
	always_ff @(posedge clk) begin
		if (take) begin
			store_q[{q_item.ch, next_q[q_item.ch]}] <= q_item.sample;
		end
		if (state_q == maf_pkg::B_READ) begin
			rdata_q <= store_q[{ch_w_q, rp}];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_w_q     <= q_item.ch;
			sample_w_q <= q_item.sample;
			sum_w_q    <= sum_q[q_item.ch] + maf_pkg::SUM_W'(q_item.sample);
			fill_w_q   <= fill_q[q_item.ch] + 1'b1;
			wp_w_q     <= next_q[q_item.ch];
		end
		if (load) begin
			result_q <= result_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= maf_pkg::B_IDLE;
			valid_q <= 1'b0;
			for (int c = 0; c < maf_pkg::CHANNELS; c++) begin
				sum_q[c]    <= '0;
				oldest_q[c] <= '0;
				next_q[c]   <= '0;
				fill_q[c]   <= '0;
			end
		end else begin
			state_q <= state_n;
			if (load) valid_q <= 1'b1;
			else if (result_ready) valid_q <= 1'b0;
			if (clear) begin
				for (int c = 0; c < maf_pkg::CHANNELS; c++) begin
					sum_q[c]    <= '0;
					oldest_q[c] <= '0;
					next_q[c]   <= '0;
					fill_q[c]   <= '0;
				end
			end else if (finish) begin
				next_q[ch_w_q] <= step_pos(wp_w_q, cap);
				if (evict) begin
					// drop the oldest sample once the window is full
					sum_q[ch_w_q]    <= sum_w_q - maf_pkg::SUM_W'(rdata_q);
					oldest_q[ch_w_q] <= step_pos(rp, cap);
					fill_q[ch_w_q]   <= fill_w_q - 1'b1;
				end else begin
					sum_q[ch_w_q]  <= sum_w_q;
					fill_q[ch_w_q] <= fill_w_q;
				end
			end
		end
	end

endmodule

FILE: rtl/multichannel_moving_average.sv
// Multichannel moving average.
// item channel: channel_index and sample_value, taken when item_valid and
// item_ready are high. result channel: filtered_value, taken when
// result_valid and result_ready are high; one result per item, in order.
// cfg channel: cfg_index 0 sets window_length (0 acts as 1, above 1024 as
// 1024) and clears every channel's sum, positions and fill count; index 1
// sets normalise_mode. cfg_ready is always high; write only when idle.
// Items enter a two-beat queue and are worked off one at a time.
// Per item the back end updates the sum and writes the sample store,
// reads the oldest entry, runs the 4-bit-per-cycle divider and then
// commits; it takes the next item from the queue only after the commit.
// An out-of-range channel gives a zero result without the divider.
// A stalled receiver holds the result register; the queue fills and then
// item_ready drops. Reset clears channel state, queue and output at once;
// the sample store is not cleared, and entries are read only once written.
module multichannel_moving_average (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [3:0]                      channel_index,
	input  logic [31:0]                     sample_value,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [31:0]                     filtered_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [maf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [10:0]                     cfg_data
);

	logic [maf_pkg::FILL_W-1:0] window_q;
	logic                       norm_q;
	logic [maf_pkg::FILL_W-1:0] cap;
	logic                       cfg_we;
	logic                       clear;
	logic                       q_valid;
	logic                       q_pop;
	maf_pkg::item_t             q_item;
	maf_pkg::back_stat_t        stat;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign clear     = cfg_we && (cfg_index == maf_pkg::REG_WINDOW_LEN);

	always_comb begin
		if (window_q == '0) cap = maf_pkg::FILL_W'(1);
		else if (window_q > maf_pkg::FILL_W'(maf_pkg::MAX_WINDOW))
			cap = maf_pkg::FILL_W'(maf_pkg::MAX_WINDOW);
		else cap = window_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= maf_pkg::WINDOW_RESET;
			norm_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == maf_pkg::REG_WINDOW_LEN) window_q <= cfg_data;
			else if (cfg_index == maf_pkg::REG_NORM_MODE) norm_q <= cfg_data[0];
		end
	end

	maf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.channel_index (channel_index),
		.sample_value  (sample_value),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	maf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.cap            (cap),
		.norm_mode      (norm_q),
		.clear          (clear),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.filtered_value (filtered_value),
		.stat           (stat)
	);

`ifndef SYNTH
	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stat.load))
		else $error("result appeared without a load from the back end");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> stat.in_div)
		else $error("divider finished outside the divide state");

	a_div_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |=> !stat.div_done)
		else $error("divider done held for more than one cycle");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	class mean_scoreboard;
		logic [maf_pkg::SAMPLE_W-1:0] ring [maf_pkg::CHANNELS][maf_pkg::MAX_WINDOW];
		logic [maf_pkg::SUM_W-1:0]    acc [maf_pkg::CHANNELS];
		int unsigned         rd_pos [maf_pkg::CHANNELS];
		int unsigned         wr_pos [maf_pkg::CHANNELS];
		int unsigned         held [maf_pkg::CHANNELS];
		int unsigned         win_len;
		bit                  norm;
		logic [31:0]         pending [$];
		int                  n_items;
		int                  n_results;
		int                  n_bad;

		function new();
			win_len = maf_pkg::MAX_WINDOW;
			norm = 0;
			clear_channels();
		endfunction

		function void clear_channels();
			for (int c = 0; c < maf_pkg::CHANNELS; c++) begin
				acc[c] = '0;
				rd_pos[c] = 0;
				wr_pos[c] = 0;
				held[c] = 0;
			end
		endfunction

		function void set_window(int unsigned v);
			win_len = v;
			clear_channels();
		endfunction

		function void note_item(logic [3:0] ch, logic [31:0] s);
			int unsigned cap;
			logic [31:0] avg;
			logic [31:0] res;
			cap = (win_len == 0) ? 1 :
				(win_len > maf_pkg::MAX_WINDOW ? maf_pkg::MAX_WINDOW : win_len);
			n_items++;
			if (ch >= maf_pkg::CHANNELS) begin
				pending.push_back('0);
				return;
			end
			ring[ch][wr_pos[ch]] = s;
			wr_pos[ch] = (wr_pos[ch] + 1 >= cap) ? 0 : wr_pos[ch] + 1;
			held[ch]++;
			acc[ch] += s;
			avg = 32'(acc[ch] / held[ch]);
			res = norm ? (maf_pkg::NORM_OFFSET + s - avg) : avg;
			if (held[ch] >= cap) begin
				acc[ch] -= ring[ch][rd_pos[ch]];
				rd_pos[ch] = (rd_pos[ch] + 1 >= cap) ? 0 : rd_pos[ch] + 1;
				held[ch]--;
			end
			pending.push_back(res);
		endfunction

		task check_result(logic [31:0] got);
			logic [31:0] exp_v;
			n_results++;
			if (pending.size() == 0) begin
				report_bad($sformatf("unexpected result %h", got));
				return;
			end
			exp_v = pending.pop_front();
			if (got !== exp_v)
				report_bad($sformatf("filtered_value %h, expected %h", got, exp_v));
		endtask

		task report_bad(string msg);
			n_bad++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [3:0]  channel_index;
	logic [31:0] sample_value;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] filtered_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [maf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [10:0] cfg_data;

	mean_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;

	multichannel_moving_average dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver side: random stall, check every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(filtered_value);
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// valid stays up after a beat until the next idle cycle or drain drops it
	task automatic send_sample(logic [3:0] ch, logic [31:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		channel_index <= ch;
		sample_value <= s;
		do @(posedge clk); while (!item_ready);
		sb.note_item(ch, s);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		item_valid <= 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [maf_pkg::CFG_IDX_W-1:0] idx, logic [10:0] v);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == maf_pkg::REG_WINDOW_LEN)
			sb.set_window(v);
		else
			sb.norm = v[0];
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(3))
			0: return 32'($urandom_range(15));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	// random run of items mostly on a few channels so windows fill up
	task automatic random_run(int n, int max_ch);
		for (int i = 0; i < n; i++)
			send_sample(4'($urandom_range(max_ch)), pick_sample());
	endtask

	initial begin
		logic [10:0] windows [6] = '{11'd1, 11'd0, 11'd2, 11'd5, 11'd1024, 11'd2047};
		sb = new();
		arst_n = 0;
		item_valid = 0;
		channel_index = '0;
		sample_value = '0;
		result_ready = 0;
		cfg_valid = 0;
		cfg_index = maf_pkg::REG_WINDOW_LEN;
		cfg_data = '0;
		send_idle_pct = 18;
		recv_idle_pct = 72;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset window, field extremes, both modes
		send_sample(4'd0, 32'h0);
		send_sample(4'd0, 32'hFFFF_FFFF);
		send_sample(4'd15, 32'hFFFF_FFFF);
		send_sample(4'd15, 32'hFFFF_FFFF);
		send_sample(4'd7, 32'hA5A5_5A5A);
		write_reg(maf_pkg::REG_NORM_MODE, 11'd1);
		send_sample(4'd0, 32'h0);
		send_sample(4'd7, 32'h5A5A_A5A5);
		send_sample(4'd15, 32'h0);
		write_reg(maf_pkg::REG_WINDOW_LEN, 11'd0);
		send_sample(4'd3, 32'h1234_5678);
		send_sample(4'd3, 32'hFFFF_FFFF);
		write_reg(maf_pkg::REG_WINDOW_LEN, 11'd3);
		for (int i = 0; i < 7; i++)
			send_sample(4'd9, 32'hFFFF_FFF0 + 32'(i));
		write_reg(maf_pkg::REG_NORM_MODE, 11'd0);
		for (int i = 0; i < 4; i++)
			send_sample(4'd9, 32'h1 << (i * 8));

		// random phases over window settings and idling profiles
		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				send_idle_pct = 72;
				recv_idle_pct = 18;
			end else if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(maf_pkg::REG_WINDOW_LEN, windows[p % 6]);
			write_reg(maf_pkg::REG_NORM_MODE, 11'(p % 2));
			random_run(windows[p % 6] >= 1024 ? 4 : 10, 1);
			random_run(4, 15);
		end
		// a full 1024 window on one channel, so drops occur at the top size
		write_reg(maf_pkg::REG_WINDOW_LEN, 11'd1024);
		send_idle_pct = 0;
		for (int i = 0; i < 1060; i++)
			send_sample(4'd4, $urandom);

		drain();
		$display("Covered %0d samples and %0d results over windows 0..2047 in both modes.",
			sb.n_items, sb.n_results);
		if (sb.n_bad == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
